FILE: rtl/golomb_encoder_top_macros.svh
// Assertion macros shared by the Golomb encoder checker.
// Included by bare file name; needs nothing else.
`ifndef GOLOMB_ENCODER_TOP_MACROS_SVH
`define GOLOMB_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GOL_ENC_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("golomb encoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GOL_ENC_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("golomb encoder: next-cycle check failed");

`endif

FILE: rtl/gol_enc_pkg.sv
// Shared constants and types of the Golomb encoder.
// No dependencies; every other file but the macros header imports this package.
`timescale 1ns / 1ps

package gol_enc_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int CHUNK_BITS    = 32;
  localparam int MAX_CODE_BITS = 2048;
  localparam int DIV_W         = 16;
  localparam int B_W           = $clog2(DIV_W + 1);
  localparam int TAIL_W        = DIV_W + 1;
  localparam int LEN_W         = 12;
  localparam int FULL_LEN_W    = SAMPLE_BITS + 2;
  localparam int CNT_W         = 6;
  localparam int DIV_CNT_W     = $clog2(SAMPLE_BITS);
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(4);

  // One classified sample: the unary stop bit followed by the binary part,
  // the total code length and the overflow flag.
  typedef struct packed {
    logic              too_long;
    logic [LEN_W-1:0]  len;
    logic [TAIL_W-1:0] tail;
  } gol_enc_desc_t;

endpackage

FILE: rtl/gol_enc_if.sv
// Valid/ready channel interfaces for samples and code chunks.
// Depends on gol_enc_pkg.
`timescale 1ns / 1ps

interface gol_enc_in_if import gol_enc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gol_enc_out_if import gol_enc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CHUNK_BITS-1:0] code_bits;
  logic [CNT_W-1:0]      bit_count;
  logic                  last_chunk;
  logic [LEN_W-1:0]      code_length;
  logic                  too_long;

  modport source (output valid, output code_bits, output bit_count, output last_chunk,
                  output code_length, output too_long, input ready);
  modport sink   (input valid, input code_bits, input bit_count, input last_chunk,
                  input code_length, input too_long, output ready);
endinterface

FILE: rtl/golomb_encoder_top.sv
// Golomb encoder with zigzag sign folding: front end, descriptor queue, back end.
// The front end takes no new sample until its one-bit-per-cycle restoring
// divider (16 steps) is done and the descriptor is in the queue; chunks of a
// code leave the back end one per cycle while the sink is ready.
// Reset is asynchronous, active low: divisor returns to 4, queue and output empty.
`timescale 1ns / 1ps

module golomb_encoder_top import gol_enc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             divisor_we_i,
  input  logic [DIV_W-1:0] divisor_wdata_i,
  gol_enc_in_if.sink       smp_i,
  gol_enc_out_if.source    code_o
);

  // The front end accepts one sample at a time. It folds the sign so that
  // small magnitudes of either sign give small codes, then runs a restoring
  // division against the divisor that was latched with the sample, so a
  // divisor write between samples never disturbs one in flight. A divisor
  // of zero is treated as one, which gives a pure unary code.
  //
  // Once the quotient and remainder are known the front end forms a compact
  // descriptor: the stop bit together with the truncated-binary remainder,
  // the total length and a flag for codes longer than the maximum. The
  // leading zeros of the unary part are implied by the length and are not
  // stored.
  //
  // The two-entry queue lets the front end start dividing the next sample
  // while the back end is still streaming out a long code, and lets the
  // back end keep sending while the front end is busy.
  //
  // The back end places the descriptor tail against the remaining length to
  // form each 32-bit chunk, one per cycle while the sink keeps up, into an
  // output register. That register is refilled in the same cycle as its
  // transfer, so a stalled sink costs nothing beyond the stall itself. An
  // over-long code produces a single flagged chunk with no bits.

  gol_enc_desc_t push_data, pop_data;
  logic          push_valid, push_ready;
  logic          pop_valid, pop_ready;

  gol_enc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .divisor_we_i    (divisor_we_i),
    .divisor_wdata_i (divisor_wdata_i),
    .smp_i           (smp_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_data_o     (push_data)
  );

  gol_enc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  gol_enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .code_o      (code_o)
  );

endmodule

FILE: rtl/gol_enc_fifo.sv
// Short descriptor queue between the front and the back of the encoder.
// Depends on gol_enc_pkg.
`timescale 1ns / 1ps

module gol_enc_fifo import gol_enc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  gol_enc_desc_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output gol_enc_desc_t pop_data_o
);

  gol_enc_desc_t           entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic                    push, pop;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/gol_enc_front.sv
// Front end: holds the divisor, takes samples, folds the sign, divides
// one quotient bit per cycle and classifies the code. Depends on gol_enc_pkg.
`timescale 1ns / 1ps

module gol_enc_front import gol_enc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               divisor_we_i,
  input  logic [DIV_W-1:0]   divisor_wdata_i,
  gol_enc_in_if.sink         smp_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output gol_enc_desc_t      push_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  function automatic logic [SAMPLE_BITS-1:0] zigzag(input logic [SAMPLE_BITS-1:0] n);
    logic [SAMPLE_BITS-1:0] sgn;
    sgn = {SAMPLE_BITS{n[SAMPLE_BITS-1]}};
    return {n[SAMPLE_BITS-2:0], 1'b0} ^ sgn;
  endfunction

  // Bit length of m-1, which is ceil(log2 m) for m >= 1.
  function automatic logic [B_W-1:0] ceil_log2(input logic [DIV_W-1:0] m);
    logic [DIV_W-1:0] mm1;
    logic [B_W-1:0]   b;
    mm1 = m - DIV_W'(1);
    b   = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (mm1[i]) b = B_W'(i + 1);
    end
    return b;
  endfunction

  logic [1:0]             state_q, state_d;
  logic [DIV_W-1:0]       divisor_q;
  logic [DIV_W-1:0]       m_q, m_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic [DIV_W-1:0]       rem_q, rem_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [B_W-1:0]         b_q, b_d;
  logic                   pow2_q, pow2_d;
  logic [TAIL_W-1:0]      u_q, u_d;

  logic [DIV_W:0]         trial;
  logic                   ge;
  logic                   accept;

  logic                   short_code;
  logic [B_W-1:0]         nb;
  logic [TAIL_W-1:0]      val;
  logic [FULL_LEN_W-1:0]  len_full;

  assign smp_i.ready = (state_q == ST_IDLE);
  assign accept      = smp_i.valid && smp_i.ready;

  assign trial = {rem_q, quo_q[SAMPLE_BITS-1]};
  assign ge    = (trial >= {1'b0, m_q});

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    b_d     = b_q;
    pow2_d  = pow2_q;
    u_d     = u_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          m_d     = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
          quo_d   = zigzag(smp_i.sample);
          rem_d   = '0;
          cnt_d   = '0;
          b_d     = ceil_log2(m_d);
          pow2_d  = ((m_d & (m_d - DIV_W'(1))) == '0);
          u_d     = (TAIL_W'(1) << b_d) - TAIL_W'(m_d);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = ge ? DIV_W'(trial - {1'b0, m_q}) : trial[DIV_W-1:0];
        quo_d = {quo_q[SAMPLE_BITS-2:0], ge};
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(SAMPLE_BITS - 1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Truncated binary: short form of b-1 bits below the threshold u.
  always_comb begin
    short_code = !pow2_q && ({1'b0, rem_q} < u_q);
    nb         = (short_code) ? b_q - B_W'(1) : b_q;
    val        = (pow2_q || short_code) ? {1'b0, rem_q} : {1'b0, rem_q} + u_q;
    len_full   = FULL_LEN_W'(quo_q) + FULL_LEN_W'(1) + FULL_LEN_W'(nb);
    push_data_o.tail     = (TAIL_W'(1) << nb) | val;
    push_data_o.len      = len_full[LEN_W-1:0];
    push_data_o.too_long = (len_full > FULL_LEN_W'(MAX_CODE_BITS));
  end

  assign push_valid_o = (state_q == ST_PUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      divisor_q <= DIVISOR_RESET;
    end else begin
      state_q <= state_d;
      if (divisor_we_i) begin
        divisor_q <= divisor_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    b_q    <= b_d;
    pow2_q <= pow2_d;
    u_q    <= u_d;
  end

endmodule

FILE: rtl/gol_enc_back.sv
// Back end: cuts each classified code into chunks and holds them in the
// output register until transferred. Depends on gol_enc_pkg.
`timescale 1ns / 1ps

module gol_enc_back import gol_enc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  gol_enc_desc_t pop_data_i,
  gol_enc_out_if.source code_o
);

  localparam int WIDE_W = TAIL_W + CHUNK_BITS;

  logic                  out_valid_q;
  logic [CHUNK_BITS-1:0] code_bits_q;
  logic [CNT_W-1:0]      bit_count_q;
  logic                  last_chunk_q;
  logic [LEN_W-1:0]      code_length_q;
  logic                  too_long_q;

  logic                  started_q;
  logic [LEN_W-1:0]      rem_q;

  logic [LEN_W-1:0]      rem;
  logic                  last;
  logic                  load;
  logic [WIDE_W-1:0]     wide;

  // rem counts code bits not yet sent; the tail ends exactly at bit rem.
  assign rem  = started_q ? rem_q : pop_data_i.len;
  assign last = pop_data_i.too_long || (rem <= LEN_W'(CHUNK_BITS));
  assign wide = {pop_data_i.tail, {CHUNK_BITS{1'b0}}} >> rem;
  assign load = pop_valid_i && (!out_valid_q || code_o.ready);

  assign pop_ready_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        started_q   <= !last;
      end else if (code_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q <= rem - LEN_W'(CHUNK_BITS);
      if (pop_data_i.too_long) begin
        code_bits_q   <= '0;
        bit_count_q   <= '0;
        last_chunk_q  <= 1'b1;
        code_length_q <= '0;
        too_long_q    <= 1'b1;
      end else begin
        code_bits_q   <= wide[CHUNK_BITS-1:0];
        bit_count_q   <= last ? rem[CNT_W-1:0] : CNT_W'(CHUNK_BITS);
        last_chunk_q  <= last;
        code_length_q <= last ? pop_data_i.len : '0;
        too_long_q    <= 1'b0;
      end
    end
  end

  assign code_o.valid       = out_valid_q;
  assign code_o.code_bits   = code_bits_q;
  assign code_o.bit_count   = bit_count_q;
  assign code_o.last_chunk  = last_chunk_q;
  assign code_o.code_length = code_length_q;
  assign code_o.too_long    = too_long_q;

endmodule

FILE: rtl/gol_enc_chk.sv
// Port-level checker for the Golomb encoder, bound to the top level.
// Depends on gol_enc_pkg and golomb_encoder_top_macros.svh.
`timescale 1ns / 1ps
`include "golomb_encoder_top_macros.svh"

module gol_enc_chk import gol_enc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [CHUNK_BITS-1:0] code_bits_i,
  input logic [CNT_W-1:0]      bit_count_i,
  input logic                  last_chunk_i,
  input logic [LEN_W-1:0]      code_length_i,
  input logic                  too_long_i
);

  `GOL_ENC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(code_bits_i) && $stable(bit_count_i) && $stable(last_chunk_i))

  `GOL_ENC_ASSERT_IMP(a_drop_shape, clk_i, rst_ni, out_valid_i && too_long_i,
    bit_count_i == '0 && last_chunk_i && code_length_i == '0 && code_bits_i == '0)

  `GOL_ENC_ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_i && !too_long_i,
    bit_count_i != '0 && bit_count_i <= CNT_W'(CHUNK_BITS))

  `GOL_ENC_ASSERT_IMP(a_mid_chunk_full, clk_i, rst_ni, out_valid_i && !last_chunk_i,
    code_length_i == '0 && bit_count_i == CNT_W'(CHUNK_BITS) && !too_long_i)

  `GOL_ENC_ASSERT_IMP(a_len_range, clk_i, rst_ni, out_valid_i && last_chunk_i && !too_long_i,
    code_length_i != '0 && code_length_i <= LEN_W'(MAX_CODE_BITS))

endmodule

bind golomb_encoder_top gol_enc_chk u_gol_enc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (code_o.valid),
  .out_ready_i   (code_o.ready),
  .code_bits_i   (code_o.code_bits),
  .bit_count_i   (code_o.bit_count),
  .last_chunk_i  (code_o.last_chunk),
  .code_length_i (code_o.code_length),
  .too_long_i    (code_o.too_long)
);

FILE: dv/golomb_code_checker.sv
// Scoreboard for the Golomb encoder: watches both channels and the divisor port.
// Predicts the code chunks of every sample transfer and compares each chunk transfer.
// Depends on gol_enc_pkg and the channel interfaces in gol_enc_if.sv.
`timescale 1ns / 1ps

module golomb_code_checker import gol_enc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             divisor_we_i,
  input  logic [DIV_W-1:0] divisor_wdata_i,
  gol_enc_in_if            smp_i,
  gol_enc_out_if           code_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [CHUNK_BITS-1:0] code_bits;
    logic [CNT_W-1:0]      bit_count;
    logic                  last_chunk;
    logic [LEN_W-1:0]      code_length;
    logic                  too_long;
  } code_chunk_t;

  code_chunk_t      expected_chunks[$];
  code_chunk_t      want;
  logic [DIV_W-1:0] golomb_m;
  int               mismatches = 0;

  assign errors_o = mismatches;

  // Appends the chunks that one sample should produce under divisor div.
  function automatic void encode_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                        input logic [DIV_W-1:0] div);
    int n, f, m, b, q, r, u, val, nb, len, pos, k, t, cnt;
    code_chunk_t c;
    n = smp;
    f = (n < 0) ? -2 * n - 1 : 2 * n;
    m = (div == '0) ? 1 : int'(div);
    b = 0;
    while ((1 << b) < m) b++;
    q = f / m;
    r = f % m;
    val = r;
    nb = b;
    // Truncated binary: short codewords for the low remainders.
    if ((m & (m - 1)) != 0) begin
      u = (1 << b) - m;
      if (r < u) nb = b - 1;
      else val = r + u;
    end
    len = q + 1 + nb;
    if (len > MAX_CODE_BITS) begin
      c = '0;
      c.last_chunk = 1'b1;
      c.too_long = 1'b1;
      expected_chunks.push_back(c);
      return;
    end
    for (k = 0; k * CHUNK_BITS < len; k++) begin
      c = '0;
      cnt = 0;
      for (t = 0; t < CHUNK_BITS && k * CHUNK_BITS + t < len; t++) begin
        pos = k * CHUNK_BITS + t;
        cnt++;
        if (pos == q) c.code_bits[CHUNK_BITS-1-t] = 1'b1;
        else if (pos > q) c.code_bits[CHUNK_BITS-1-t] = 1'((val >> (nb - pos + q)) & 1);
      end
      c.bit_count = CNT_W'(cnt);
      if ((k + 1) * CHUNK_BITS >= len) begin
        c.last_chunk = 1'b1;
        c.code_length = LEN_W'(len);
      end
      expected_chunks.push_back(c);
    end
  endfunction

  function automatic void check_field(input string field, input logic [CHUNK_BITS-1:0] exp_v,
                                      input logic [CHUNK_BITS-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      golomb_m = DIVISOR_RESET;
      expected_chunks.delete();
      pending_o <= 0;
    end else begin
      if (code_i.valid && code_i.ready) begin
        if (expected_chunks.size() == 0) begin
          $error("unexpected chunk transfer: code_bits 0x%0h", code_i.code_bits);
          mismatches++;
        end else begin
          want = expected_chunks.pop_front();
          check_field("code_bits", want.code_bits, code_i.code_bits);
          check_field("bit_count", want.bit_count, code_i.bit_count);
          check_field("last_chunk", want.last_chunk, code_i.last_chunk);
          check_field("code_length", want.code_length, code_i.code_length);
          check_field("too_long", want.too_long, code_i.too_long);
        end
      end
      if (smp_i.valid && smp_i.ready) encode_sample(smp_i.sample, golomb_m);
      if (divisor_we_i) golomb_m = divisor_wdata_i;
      pending_o <= expected_chunks.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// Top-level testbench of the Golomb encoder: clock, reset, stimulus and verdict.
// Depends on gol_enc_pkg, gol_enc_if.sv, golomb_encoder_top and golomb_code_checker.
`timescale 1ns / 1ps

module tb_top;
  import gol_enc_pkg::*;

  // Longest stretch without any transfer that a correct run can show is a sender
  // gap plus the divider latency plus a receiver stall; the limit leaves a wide
  // margin over that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 448;
  localparam int DIRECTED_N     = 22;

  logic             clk_i;
  logic             rst_ni;
  logic             divisor_we_i;
  logic [DIV_W-1:0] divisor_wdata_i;
  int               errors;
  int               pending;
  int               quiet_cycles = 0;
  bit               calm = 1'b0;
  logic [DIV_W-1:0] cur_div = DIVISOR_RESET;

  // Directed part: each entry gives the divisor in force and the sample sent.
  // It walks through the reset divisor, a zero divisor (unary only), a divisor
  // of one, a non-power of two with both short and long remainder codewords,
  // the largest divisor and the largest power of two. Samples cover zero, the
  // field extremes, codes that exactly fill the maximum length and codes one
  // bit too long.
  int dir_div [DIRECTED_N] = '{4, 4, 4, 4, 4, 4, 4, 0, 0, 0, 0, 1, 1, 1, 3, 3, 3,
                               65535, 65535, 65535, 32768, 32768};
  int dir_smp [DIRECTED_N] = '{0, 1, -1, 32767, -32768, 7, -8, 0, -1, -1024, 1024,
                               0, 5, -5, 0, 1, -1, 32767, -32768, 0, -32768, 32767};

  gol_enc_in_if  smp_if();
  gol_enc_out_if code_if();

  golomb_encoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .divisor_we_i    (divisor_we_i),
    .divisor_wdata_i (divisor_wdata_i),
    .smp_i           (smp_if),
    .code_o          (code_if)
  );

  golomb_code_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .divisor_we_i    (divisor_we_i),
    .divisor_wdata_i (divisor_wdata_i),
    .smp_i           (smp_if),
    .code_i          (code_if),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always #1 clk_i = ~clk_i;

  // Idle length for either side. Most gaps are short, a few are long, and in a
  // calm phase there are none at all so that back-to-back transfers occur.
  function automatic int idle_len();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample for effective divisor m. Mostly small multiples of m so that the
  // codes stay a handful of chunks long, some near the length limit, and some
  // fully random words so that every input bit toggles.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int m);
    int lim, sel, mag;
    sel = $urandom_range(0, 9);
    if (sel < 2) return SAMPLE_BITS'($urandom);
    lim = (sel >= 8) ? m * 1100 : m * $urandom_range(1, 40);
    if (lim > 32767) lim = 32767;
    mag = $urandom_range(0, lim);
    return $urandom_range(0, 1) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
  endfunction

  // Presents one sample and returns at the rising edge of its transfer. The
  // valid line stays high on return; it is only lowered after a gap is chosen,
  // so a back-to-back transfer never sees valid dropped and raised in one step.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
  endtask

  // Stops the sender and waits until every predicted chunk has been transferred.
  task automatic drain();
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // The divisor is only changed with the encoder idle, so every sample is
  // encoded under a single, known divisor.
  task automatic set_divisor(input logic [DIV_W-1:0] value);
    drain();
    divisor_we_i    <= 1'b1;
    divisor_wdata_i <= value;
    @(negedge clk_i);
    divisor_we_i <= 1'b0;
    cur_div = value;
  endtask

  // Receiver: ready is held high for short runs broken by stalls of random
  // length, so stalls land on every chunk position of a code.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      code_if.ready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
      n = idle_len();
      if (n > 0) begin
        @(negedge clk_i);
        code_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  // Watchdog: a run that goes quiet for too long has hung.
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (code_if.valid && code_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[golomb_encoder_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    int sent, phase_len, eff;
    logic [DIV_W-1:0] d;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    divisor_we_i    = 1'b0;
    divisor_wdata_i = '0;
    smp_if.valid    = 1'b0;
    smp_if.sample   = '0;
    code_if.ready   = 1'b0;
    sent            = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_N; i++) begin
      if (dir_div[i] != cur_div) set_divisor(DIV_W'(dir_div[i]));
      send_sample(SAMPLE_BITS'(dir_smp[i]));
    end

    // Random phases: each picks a divisor class, including the extremes, and
    // may run calm. Now and then the sender holds off until the encoder has
    // emptied completely. The last phase is cut short at the item budget.
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       d = '0;
        1:       d = DIV_W'(1);
        2:       d = '1;
        3:       d = DIV_W'(1) << $urandom_range(1, 15);
        4:       d = DIV_W'($urandom_range(2, 16));
        5:       d = DIV_W'($urandom_range(17, 1000));
        default: d = DIV_W'($urandom);
      endcase
      set_divisor(d);
      calm = ($urandom_range(0, 4) == 0);
      eff = (d == '0) ? 1 : int'(d);
      phase_len = $urandom_range(15, 50);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        if ($urandom_range(0, 29) == 0) drain();
        send_sample(pick_sample(eff));
        sent++;
      end
    end

    // Let the last codes come out, then allow a few more cycles for any
    // stray chunk to show up.
    calm = 1'b0;
    drain();
    repeat (40) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[golomb_encoder_top] OK");
    end else begin
      $display("[golomb_encoder_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: golomb_encoder_top.f
+incdir+rtl
rtl/gol_enc_pkg.sv
rtl/gol_enc_if.sv
rtl/gol_enc_fifo.sv
rtl/gol_enc_front.sv
rtl/gol_enc_back.sv
rtl/golomb_encoder_top.sv
rtl/gol_enc_chk.sv
dv/golomb_code_checker.sv
dv/tb_top.sv
